[rtl/bft_pkg.sv]
// package for the bucketed forwarding table: sizes, field layouts, codes
// no dependencies
`default_nettype none

package bft_pkg;

    localparam int TableDepth = 16384;
    localparam int BucketWays = 4;
    localparam int SlotW      = $clog2(TableDepth);
    localparam int WayW       = $clog2(BucketWays);
    localparam int SlotOutW   = 14;

    localparam logic [11:0] VlanMask = 12'h0FFF;
    localparam logic [63:0] MacMask  = 64'h0000_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXISTS    = 2'd1,
        ST_NO_ROOM   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } result_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_WRITE,
        S_CLEAR,
        S_FLUSH,
        S_DONE
    } state_t;

    // stored entry: valid, tag (kind, vlan), key, attributes
    typedef struct packed {
        logic        valid;
        logic        drop;
        logic [11:0] group;
        logic [6:0]  port;
        logic [4:0]  device;
        logic        stat;
        logic [1:0]  prio;
        logic        kind;
        logic [11:0] vlan;
        logic [63:0] key;
    } entry_t;

    // input payload, first field in the high bits
    typedef struct packed {
        logic [1:0]  filter_select;
        logic        drop_flag;
        logic [11:0] dest_group;
        logic [6:0]  dest_port;
        logic [4:0]  dest_device;
        logic        static_flag;
        logic [1:0]  priority_req;
        logic [13:0] bucket;
        logic [63:0] key_bits;
        logic [11:0] vlan;
        logic        key_kind;
        logic [1:0]  op;
    } req_t;

endpackage

`default_nettype wire

[rtl/bucketed_forwarding_table.sv]
// bucketed forwarding table top level; memory, sequencer and result register
// depends on bft_pkg
`default_nettype none

// Four-way bucketed forwarding table held in one synchronous memory with one
// read port and one write port.
// Input channel s_axis: one request per transfer (insert, remove, flush).
// Output channel m_axis: exactly one result per request (status, slot).
// Insert and remove read the bucket's slots one per cycle, at most four and
// stopping at a matching key, then write at most one slot and set the result.
// One request in flight at a time. The unused op answers with status OK in
// the cycle after accept.
// Flush walks every slot with a read and a conditional write-back.
// After reset a clearing pass writes zero to all TableDepth (16384) slots, one
// per cycle; s_axis_tready stays low until it ends.
// A finished result waits in the output register while m_axis_tready is low;
// the next request is accepted only once the result has been taken.
module bucketed_forwarding_table
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // op, key_kind, vlan, key_bits, bucket, priority_req, static_flag,
    // dest_device, dest_port, dest_group, drop_flag, filter_select, 5 zero bits
    input  wire logic [127:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status, slot
    output logic [15:0]       m_axis_tdata
);
    import bft_pkg::*;

    entry_t mem [TableDepth];
    entry_t rd_data;
    logic               we;
    logic [SlotW-1:0]   waddr, raddr;
    entry_t             wdata;

    // memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[raddr];
    end

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [SlotW:0]     cnt_reg, cnt_next;      // way or slot walk counter
    logic               rdv_reg, rdv_next;      // read data valid next cycle
    logic [SlotW-1:0]   rslot_reg, rslot_next;  // slot of data in rd_data
    logic               have_reg, have_next;
    logic               hit_reg, hit_next;      // key match, finish probe
    logic [1:0]         bpri_reg, bpri_next;
    logic [SlotW-1:0]   best_reg, best_next;
    logic [1:0]         stat_reg, stat_next;
    logic [SlotOutW-1:0] oslot_reg, oslot_next;
    logic               ovalid_reg, ovalid_next;
    entry_t             hold_reg;               // last probed entry

    logic        accept;
    logic [63:0] key_eff;
    logic        kmatch;
    logic [SlotW-1:0] probe_addr;
    logic        flush_kill;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {oslot_reg, stat_reg};

    // masked key and compare against the slot just read
    assign key_eff = req_reg.key_kind ? req_reg.key_bits : (req_reg.key_bits & MacMask);
    assign kmatch  = (rd_data.kind == req_reg.key_kind) && (rd_data.vlan == req_reg.vlan)
                     && (rd_data.key == key_eff);
    assign probe_addr = SlotW'(req_reg.bucket) + SlotW'(cnt_reg[WayW-1:0]);
    assign flush_kill = rd_data.valid
        && (!req_reg.filter_select[0] || rd_data.vlan == (req_reg.vlan & VlanMask))
        && (!req_reg.filter_select[1] || (rd_data.device == req_reg.dest_device
                                          && rd_data.port == req_reg.dest_port))
        && (req_reg.static_flag || !rd_data.stat);

    // next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rdv_next    = 1'b0;
        rslot_next  = rslot_reg;
        have_next   = have_reg;
        hit_next    = hit_reg;
        bpri_next   = bpri_reg;
        best_next   = best_reg;
        stat_next   = stat_reg;
        oslot_next  = oslot_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (SlotW+1)'(TableDepth - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next  = '0;
                    have_next = 1'b0;
                    hit_next  = 1'b0;
                    bpri_next = s_axis_tdata[94:93];
                    best_next = '0;
                    case (op_t'(s_axis_tdata[1:0]))
                        OP_INSERT, OP_REMOVE: state_next = S_PROBE;
                        OP_FLUSH:             state_next = S_FLUSH;
                        default:
                        begin
                            stat_next   = ST_OK;
                            oslot_next  = '0;
                            ovalid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                // issue reads for each way, evaluate the previous one
                if (cnt_reg < (SlotW+1)'(BucketWays) && !hit_reg)
                begin
                    rdv_next   = 1'b1;
                    rslot_next = probe_addr;
                    cnt_next   = cnt_reg + 1'b1;
                end
                if (rdv_reg && !hit_reg)
                begin
                    if (req_reg.op == OP_REMOVE)
                    begin
                        if (rd_data.valid && kmatch)
                        begin
                            hit_next  = 1'b1;
                            have_next = 1'b1;
                            best_next = rslot_reg;
                        end
                    end
                    else if (kmatch)
                    begin
                        hit_next = 1'b1;
                        if (!rd_data.valid || rd_data.prio <= req_reg.priority_req)
                        begin
                            have_next = 1'b1;
                            best_next = rslot_reg;
                        end
                        else
                        begin
                            have_next = 1'b0;
                            stat_next = ST_EXISTS;
                        end
                    end
                    else if (bpri_reg != 2'd0)
                    begin
                        if (!rd_data.valid)
                        begin
                            bpri_next = 2'd0;
                            best_next = rslot_reg;
                            have_next = 1'b1;
                        end
                        else if (bpri_reg > rd_data.prio)
                        begin
                            bpri_next = rd_data.prio;
                            best_next = rslot_reg;
                            have_next = 1'b1;
                        end
                    end
                end
                if (hit_next || (!rdv_next && !rdv_reg))
                begin
                    state_next = S_WRITE;
                end
                else if (!rdv_next && rdv_reg)
                begin
                    state_next = S_PROBE;
                end
            end
            S_WRITE:
            begin
                state_next  = S_DONE;
                ovalid_next = 1'b1;
                if (have_reg)
                begin
                    stat_next  = ST_OK;
                    oslot_next = SlotOutW'(best_reg);
                end
                else
                begin
                    oslot_next = '0;
                    if (!(hit_reg && req_reg.op == OP_INSERT))
                    begin
                        stat_next = (req_reg.op == OP_REMOVE) ? ST_NOT_FOUND : ST_NO_ROOM;
                    end
                end
            end
            S_FLUSH:
            begin
                // alternate: read slot, then write back if filtered out
                if (!rdv_reg)
                begin
                    if (cnt_reg == (SlotW+1)'(TableDepth))
                    begin
                        state_next  = S_DONE;
                        stat_next   = ST_OK;
                        oslot_next  = '0;
                        ovalid_next = 1'b1;
                    end
                    else
                    begin
                        rdv_next   = 1'b1;
                        rslot_next = cnt_reg[SlotW-1:0];
                        cnt_next   = cnt_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory port control
    always_comb
    begin
        we    = 1'b0;
        waddr = rslot_reg;
        wdata = rd_data;
        raddr = rslot_next;
        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = cnt_reg[SlotW-1:0];
                wdata = '0;
            end
            S_WRITE:
            begin
                waddr = best_reg;
                we    = have_reg;
                if (req_reg.op == OP_REMOVE)
                begin
                    // remove keeps the stored key and attributes of the hit
                    wdata       = hold_reg;
                    wdata.valid = 1'b0;
                end
                else
                begin
                    wdata.valid  = 1'b1;
                    wdata.drop   = req_reg.drop_flag;
                    wdata.group  = req_reg.dest_group;
                    wdata.port   = req_reg.dest_port;
                    wdata.device = req_reg.dest_device;
                    wdata.stat   = req_reg.static_flag;
                    wdata.prio   = req_reg.priority_req;
                    wdata.kind   = req_reg.key_kind;
                    wdata.vlan   = req_reg.vlan;
                    wdata.key    = key_eff;
                end
            end
            S_FLUSH:
            begin
                if (rdv_reg && flush_kill)
                begin
                    we          = 1'b1;
                    wdata.valid = 1'b0;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // copy of each probed entry; the hit one is the last taken
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PROBE && rdv_reg && !hit_reg)
        begin
            hold_reg <= rd_data;
        end
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cnt_reg    <= '0;
            rdv_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rdv_reg    <= rdv_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_t'(s_axis_tdata[122:0]);
        end
        rslot_reg <= rslot_next;
        have_reg  <= have_next;
        hit_reg   <= hit_next;
        bpri_reg  <= bpri_next;
        best_reg  <= best_next;
        stat_reg  <= stat_next;
        oslot_reg <= oslot_next;
    end

`ifndef NO_ASSERTIONS
    // a result never appears while a request is being taken in
    assert property (@(posedge clk) disable iff (!rst_n) !(m_axis_tvalid && s_axis_tready))
        else $error("input ready while result pending");
    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // no memory write while idle
    assert property (@(posedge clk) disable iff (!rst_n) state_reg == S_IDLE |-> !we)
        else $error("memory write while idle");
`endif

endmodule

`default_nettype wire
